// ----- rtl/core/skfs_pkg.sv -----
`timescale 1ns / 1ps

package skfs_pkg;

  localparam int unsigned OP_W  = 2;
  localparam int unsigned IDX_W = 10;
  localparam int unsigned KEY_W = 32;
  localparam int unsigned CNT_W = 11;

  // operation codes of a request
  localparam logic [OP_W-1:0] OP_WRITE   = 2'd0;
  localparam logic [OP_W-1:0] OP_NEAREST = 2'd1;
  localparam logic [OP_W-1:0] OP_EXACT   = 2'd2;

  typedef enum logic [1:0] {
    KIND_WRITE,
    KIND_SEARCH,
    KIND_NOP
  } kind_e;

  typedef struct packed {
    kind_e             kind;
    logic [IDX_W-1:0]  entry_index;
    logic [KEY_W-1:0]  key_value;
  } cmd_t;

  typedef struct packed {
    logic [IDX_W-1:0]  result_index;
    logic              matched;
  } res_t;

endpackage

// ----- rtl/core/skfs_fifo.sv -----
`timescale 1ns / 1ps

module skfs_fifo #(
  parameter int unsigned WIDTH = 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o
);

  // two-entry queue
  logic [WIDTH-1:0] slot_q [2];
  logic             wptr_q, wptr_d;
  logic             rptr_q, rptr_d;
  logic [1:0]       cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign rdata_o = slot_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wptr_d = wptr_q ^ do_push;
    rptr_d = rptr_q ^ do_pop;
    cnt_d  = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wptr_q] <= wdata_i;
    end
  end

endmodule

// ----- rtl/core/skfs_front.sv -----
`timescale 1ns / 1ps

module skfs_front
  import skfs_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  output logic             full_o,
  input  logic [OP_W-1:0]  operation_i,
  input  logic [IDX_W-1:0] entry_index_i,
  input  logic [KEY_W-1:0] key_value_i,
  output logic             cmd_valid_o,
  output cmd_t             cmd_o,
  input  logic             cmd_pop_i
);

  cmd_t cmd_in;
  logic cmd_empty;

  always_comb begin
    cmd_in.entry_index = entry_index_i;
    cmd_in.key_value   = key_value_i;
    unique case (operation_i) inside
      OP_WRITE:             cmd_in.kind = KIND_WRITE;
      OP_NEAREST, OP_EXACT: cmd_in.kind = KIND_SEARCH;
      default:              cmd_in.kind = KIND_NOP;
    endcase
  end

  skfs_fifo #(
    .WIDTH($bits(cmd_t))
  ) u_cmd_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push_i),
    .wdata_i (cmd_in),
    .full_o  (full_o),
    .pop_i   (cmd_pop_i),
    .rdata_o (cmd_o),
    .empty_o (cmd_empty)
  );

  assign cmd_valid_o = !cmd_empty;

endmodule

// ----- rtl/core/skfs_back.sv -----
`timescale 1ns / 1ps

module skfs_back
  import skfs_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 1024
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [CNT_W-1:0] entry_count_i,
  input  logic             cmd_valid_i,
  input  cmd_t             cmd_i,
  output logic             cmd_pop_o,
  output logic             res_valid_o,
  output res_t             res_o,
  input  logic             res_full_i
);

  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SEARCH = 2'd1;
  localparam logic [1:0] ST_FINAL  = 2'd2;
  localparam logic [1:0] ST_DONE   = 2'd3;

  logic [KEY_W-1:0] mem_q [TABLE_DEPTH];
  logic [KEY_W-1:0] rdata_q;

  logic [1:0]       state_q, state_d;
  logic [CW-1:0]    lo_q, lo_d, hi_q, hi_d;
  logic [AW-1:0]    mid_q, mid_d;
  logic [KEY_W-1:0] key_q, key_d;
  res_t             res_q, res_d;

  logic [CW-1:0]    hi_eff;
  logic [CW-1:0]    lo_n, hi_n;
  logic             key_lt, key_eq, last_step;
  logic             in_range;
  logic             we, rd_en;
  logic [AW-1:0]    rd_addr;

  function automatic logic [AW-1:0] mid_of(input logic [CW-1:0] lo, input logic [CW-1:0] hi);
    logic [CW:0] sum;
    sum = {1'b0, lo} + {1'b0, hi};
    return AW'(sum >> 1);
  endfunction

  // search span, saturated at the table depth
  always_comb begin
    if (32'(entry_count_i) > 32'(TABLE_DEPTH)) begin
      hi_eff = CW'(TABLE_DEPTH);
    end else begin
      hi_eff = CW'(entry_count_i);
    end
  end

  assign in_range = (32'(cmd_i.entry_index) < 32'(TABLE_DEPTH));

  // one bisection step on the entry read last cycle
  assign key_lt    = (rdata_q < key_q);
  assign key_eq    = (rdata_q == key_q);
  assign lo_n      = key_lt ? CW'(mid_q) : lo_q;
  assign hi_n      = key_lt ? hi_q : CW'(mid_q);
  assign last_step = (({1'b0, lo_n} + 1'b1) >= {1'b0, hi_n});

  always_comb begin
    state_d     = state_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    mid_d       = mid_q;
    key_d       = key_q;
    res_d       = res_q;
    rd_addr     = mid_q;
    rd_en       = 1'b0;
    we          = 1'b0;
    cmd_pop_o   = 1'b0;
    res_valid_o = 1'b0;
    res_o       = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          unique case (cmd_i.kind)
            KIND_WRITE: begin
              res_valid_o        = 1'b1;
              res_o.result_index = cmd_i.entry_index;
              if (!res_full_i) begin
                cmd_pop_o = 1'b1;
                we        = in_range;
              end
            end
            KIND_SEARCH: begin
              if (hi_eff == '0) begin
                res_valid_o = 1'b1;
                cmd_pop_o   = !res_full_i;
              end else begin
                cmd_pop_o = 1'b1;
                key_d     = cmd_i.key_value;
                lo_d      = '0;
                hi_d      = hi_eff;
                rd_addr   = mid_of('0, hi_eff);
                mid_d     = rd_addr;
                rd_en     = 1'b1;
                state_d   = ST_SEARCH;
              end
            end
            default: begin
              res_valid_o = 1'b1;
              cmd_pop_o   = !res_full_i;
            end
          endcase
        end
      end
      ST_SEARCH: begin
        if (key_eq) begin
          res_d.result_index = IDX_W'(mid_q);
          res_d.matched      = 1'b1;
          state_d            = ST_DONE;
        end else begin
          lo_d  = lo_n;
          hi_d  = hi_n;
          rd_en = 1'b1;
          if (last_step) begin
            rd_addr = AW'(lo_n);
            state_d = ST_FINAL;
          end else begin
            rd_addr = mid_of(lo_n, hi_n);
          end
          mid_d = rd_addr;
        end
      end
      ST_FINAL: begin
        res_d.result_index = IDX_W'(mid_q);
        res_d.matched      = key_eq;
        state_d            = ST_DONE;
      end
      ST_DONE: begin
        res_valid_o = 1'b1;
        res_o       = res_q;
        if (!res_full_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q  <= lo_d;
    hi_q  <= hi_d;
    mid_q <= mid_d;
    key_q <= key_d;
    res_q <= res_d;
  end

  // key table, one write or one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[AW'(cmd_i.entry_index)] <= cmd_i.key_value;
    end
    if (rd_en) begin
      rdata_q <= mem_q[rd_addr];
    end
  end

endmodule

// ----- rtl/core/sorted_key_floor_search_unit.sv -----
// flow: a write, an unknown request or an empty-table search is answered from the idle state;
// a search runs s = max(1, ceil(log2(n))) bisection steps of one registered table read each,
// n = min(entry_count, TABLE_DEPTH), then a final compare, ending early on a hit
// throughput: one write per cycle if the result queue has room; a search holds the back end
// reset: asynchronous active low, clears both queues, the sequencer and entry_count;
// the key table is not cleared and holds nothing meaningful until written
`timescale 1ns / 1ps

module sorted_key_floor_search_unit
  import skfs_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 1024
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  // configuration: entry_count register
  input  logic             cfg_we_i,
  input  logic [CNT_W-1:0] cfg_wdata_i,
  // request side
  input  logic             push,
  output logic             full,
  input  logic [OP_W-1:0]  operation_i,
  input  logic [IDX_W-1:0] entry_index_i,
  input  logic [KEY_W-1:0] key_value_i,
  // result side
  output logic             empty,
  input  logic             pop,
  output logic [IDX_W-1:0] result_index_o,
  output logic             matched_o
);

  logic [CNT_W-1:0] entry_count_q;

  // front to back command queue
  logic cmd_valid;
  cmd_t cmd;
  logic cmd_pop;

  // back to result queue
  logic res_valid;
  res_t res_in;
  logic res_full;
  res_t res_out;

  // entry_count is to be changed only while the block is idle; the block does not enforce it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_count_q <= '0;
    end else if (cfg_we_i) begin
      entry_count_q <= cfg_wdata_i;
    end
  end

  // front end: classifies each request and queues it
  skfs_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push),
    .full_o        (full),
    .operation_i   (operation_i),
    .entry_index_i (entry_index_i),
    .key_value_i   (key_value_i),
    .cmd_valid_o   (cmd_valid),
    .cmd_o         (cmd),
    .cmd_pop_i     (cmd_pop)
  );

  // back end: table writes and the bisection sequencer over the key table
  skfs_back #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .entry_count_i (entry_count_q),
    .cmd_valid_i   (cmd_valid),
    .cmd_i         (cmd),
    .cmd_pop_o     (cmd_pop),
    .res_valid_o   (res_valid),
    .res_o         (res_in),
    .res_full_i    (res_full)
  );

  // result queue decouples the back end from the consumer
  skfs_fifo #(
    .WIDTH($bits(res_t))
  ) u_res_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_valid),
    .wdata_i (res_in),
    .full_o  (res_full),
    .pop_i   (pop),
    .rdata_o (res_out),
    .empty_o (empty)
  );

  assign result_index_o = res_out.result_index;
  assign matched_o      = res_out.matched;

endmodule

// ----- rtl/core/skfs_checker.sv -----
`timescale 1ns / 1ps

module skfs_checker
  import skfs_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             push,
  input logic             full,
  input logic             empty,
  input logic             pop,
  input logic [IDX_W-1:0] result_index_o,
  input logic             matched_o
);

  // requests taken but whose result is not yet popped
  logic [3:0] pending_q;
  logic       in_acc, out_acc;

  assign in_acc  = push && !full;
  assign out_acc = pop && !empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else begin
      pending_q <= pending_q + 4'(in_acc) - 4'(out_acc);
    end
  end

  a_reset_empty: assert property (@(posedge clk_i) !rst_ni |=> empty)
    else $error("result queue not empty after reset");

  a_hold_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty && $stable(result_index_o) && $stable(matched_o))
    else $error("stalled result changed");

  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> pending_q != 4'd0)
    else $error("result without a request");

  a_idle_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_q == 4'd0 |-> !full)
    else $error("full with nothing pending");

  a_no_bypass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && pending_q == 4'd0 |=> empty)
    else $error("result in the cycle after its request");

endmodule

bind sorted_key_floor_search_unit skfs_checker u_checker (.*);

// ----- tb/sorted_key_floor_search_unit_checker.sv -----
`timescale 1ns / 1ps

module sorted_key_floor_search_unit_checker
  import skfs_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 1024
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CNT_W-1:0] cfg_wdata_i,
  input  logic             push_i,
  input  logic             full_i,
  input  logic [OP_W-1:0]  operation_i,
  input  logic [IDX_W-1:0] entry_index_i,
  input  logic [KEY_W-1:0] key_value_i,
  input  logic             empty_i,
  input  logic             pop_i,
  input  logic [IDX_W-1:0] result_index_i,
  input  logic             matched_i,
  output int unsigned      mismatch_count_o,
  output int unsigned      outstanding_o
);

  logic [KEY_W-1:0] key_store [TABLE_DEPTH];
  logic [CNT_W-1:0] entry_count;
  res_t             awaited_results [$];
  int unsigned      mismatch_count = 0;

  assign mismatch_count_o = mismatch_count;

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("%0t ns: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    mismatch_count++;
  endtask

  // bisection over the first n entries, floor index of the key
  function automatic logic [IDX_W-1:0] floor_of_key(input logic [KEY_W-1:0] key,
                                                    input int unsigned n);
    int unsigned lo;
    int unsigned hi;
    int unsigned mid;
    logic [KEY_W-1:0] probe;
    lo  = 0;
    hi  = n;
    mid = 0;
    while (1) begin
      mid   = (lo + hi) / 2;
      probe = key_store[mid];
      if (probe < key) lo = mid;
      else if (probe > key) hi = mid;
      else break;
      if (lo + 1 >= hi) begin
        mid = lo;
        break;
      end
    end
    return mid[IDX_W-1:0];
  endfunction

  function automatic res_t resolve_request(input logic [OP_W-1:0]  op,
                                           input logic [IDX_W-1:0] idx,
                                           input logic [KEY_W-1:0] key);
    res_t        res;
    int unsigned n;
    res = '0;
    case (op)
      OP_WRITE: begin
        if (idx < TABLE_DEPTH) key_store[idx] = key;
        res.result_index = idx;
      end
      OP_NEAREST, OP_EXACT: begin
        n = (entry_count > TABLE_DEPTH) ? TABLE_DEPTH : entry_count;
        if (n != 0) begin
          res.result_index = floor_of_key(key, n);
          res.matched      = (key_store[res.result_index] == key);
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    res_t want;
    if (!rst_ni) begin
      entry_count = '0;
      awaited_results.delete();
      outstanding_o <= 0;
    end else begin
      if (cfg_we_i) entry_count = cfg_wdata_i;
      if (pop_i && !empty_i) begin
        if (awaited_results.size() == 0) begin
          report_mismatch("result without request (index)", result_index_i, 0);
        end else begin
          want = awaited_results.pop_front();
          if (result_index_i !== want.result_index)
            report_mismatch("result_index", result_index_i, want.result_index);
          if (matched_i !== want.matched)
            report_mismatch("matched", matched_i, want.matched);
        end
      end
      if (push_i && !full_i)
        awaited_results.push_back(resolve_request(operation_i, entry_index_i, key_value_i));
      outstanding_o <= awaited_results.size();
    end
  end

endmodule

// ----- tb/sorted_key_floor_search_unit_tb.sv -----
`timescale 1ns / 1ps

module sorted_key_floor_search_unit_tb;
  import skfs_pkg::*;

  localparam int unsigned      TABLE_DEPTH = 1024;
  // operation code that the block must treat as a no-op
  localparam logic [OP_W-1:0]  OP_UNUSED   = 2'd3;
  localparam logic [KEY_W-1:0] KEY_MAX     = '1;
  // cycles with no handshake or register write before the run is declared hung
  localparam int unsigned      STALL_LIMIT = 2000;
  // leave some margin at the end of the run
  localparam int unsigned      TAIL_CYCLES = 40;

  logic             clk;
  logic             rst_n       = 1'b0;
  logic             cfg_we      = 1'b0;
  logic [CNT_W-1:0] cfg_wdata   = '0;
  logic             push        = 1'b0;
  logic             full;
  logic [OP_W-1:0]  operation   = '0;
  logic [IDX_W-1:0] entry_index = '0;
  logic [KEY_W-1:0] key_value   = '0;
  logic             empty;
  logic             pop         = 1'b0;
  logic [IDX_W-1:0] result_index;
  logic             matched;

  int unsigned mismatch_count;
  int unsigned outstanding;
  int unsigned send_gap_pct  = 29;
  int unsigned pop_idle_pct  = 54;
  int unsigned requests_sent = 0;
  int unsigned quiet_cycles  = 0;
  // entries a search may touch under the current entry_count
  int unsigned live_entries  = 0;
  // stimulus copy of the table, used only to pick meaningful keys
  logic [KEY_W-1:0] table_image [TABLE_DEPTH];

  sorted_key_floor_search_unit #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) i_dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_wdata_i   (cfg_wdata),
    .push          (push),
    .full          (full),
    .operation_i   (operation),
    .entry_index_i (entry_index),
    .key_value_i   (key_value),
    .empty         (empty),
    .pop           (pop),
    .result_index_o(result_index),
    .matched_o     (matched)
  );

  sorted_key_floor_search_unit_checker #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) i_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata),
    .push_i          (push),
    .full_i          (full),
    .operation_i     (operation),
    .entry_index_i   (entry_index),
    .key_value_i     (key_value),
    .empty_i         (empty),
    .pop_i           (pop),
    .result_index_i  (result_index),
    .matched_i       (matched),
    .mismatch_count_o(mismatch_count),
    .outstanding_o   (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // result side: pop decided fresh every cycle
  always @(posedge clk) begin
    pop <= ($urandom_range(0, 99) >= pop_idle_pct);
  end

  // watchdog: any handshake or register write counts as progress
  always @(posedge clk) begin
    if (rst_n) begin
      if ((push && !full) || (pop && !empty) || cfg_we) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // one request, with random idle cycles in front; returns once full reads low after an edge
  task automatic send_request(input logic [OP_W-1:0]  op,
                              input logic [IDX_W-1:0] idx,
                              input logic [KEY_W-1:0] key);
    // idle profile: receiver slow first, then sender slow, then full speed
    if (requests_sent < 620) begin
      send_gap_pct = 29;
      pop_idle_pct = 54;
    end else if (requests_sent < 1240) begin
      send_gap_pct = 54;
      pop_idle_pct = 29;
    end else begin
      send_gap_pct = 0;
      pop_idle_pct = 0;
    end
    while ($urandom_range(0, 99) < send_gap_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push        <= 1'b1;
    operation   <= op;
    entry_index <= idx;
    key_value   <= key;
    @(posedge clk);
    while (full) @(posedge clk);
    requests_sent++;
  endtask

  // hold requests back until every result has been taken
  task automatic drain_results();
    push <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // register write, only ever issued with the block idle
  task automatic set_entry_count(input int unsigned count);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_wdata <= CNT_W'(count);
    @(posedge clk);
    cfg_we       <= 1'b0;
    live_entries = (count > TABLE_DEPTH) ? TABLE_DEPTH : count;
  endtask

  // mostly keys that sit on or right next to a live entry
  function automatic logic [KEY_W-1:0] pick_search_key();
    int unsigned      slot;
    logic [KEY_W-1:0] base;
    slot = $urandom_range(0, (live_entries == 0) ? TABLE_DEPTH - 1 : live_entries - 1);
    base = table_image[slot];
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return base;
      5:             return base + 1;
      6:             return base - 1;
      7:             return $urandom;
      8:             return '0;
      default:       return KEY_MAX;
    endcase
  endfunction

  task automatic random_request();
    int unsigned      roll;
    int unsigned      slot;
    logic [KEY_W-1:0] lo_key;
    logic [KEY_W-1:0] hi_key;
    logic [KEY_W-1:0] key;
    roll = $urandom_range(0, 99);
    if (roll < 40) begin
      send_request(OP_NEAREST, IDX_W'($urandom), pick_search_key());
    end else if (roll < 75) begin
      send_request(OP_EXACT, IDX_W'($urandom), pick_search_key());
    end else if (roll < 88) begin
      // rewrite that keeps the table ascending
      slot   = $urandom_range(0, TABLE_DEPTH - 1);
      lo_key = (slot == 0) ? '0 : table_image[slot-1];
      hi_key = (slot == TABLE_DEPTH - 1) ? KEY_MAX : table_image[slot+1];
      key    = (hi_key >= lo_key) ? lo_key + $urandom_range(0, hi_key - lo_key) : lo_key;
      table_image[slot] = key;
      send_request(OP_WRITE, IDX_W'(slot), key);
    end else if (roll < 97) begin
      send_request(OP_UNUSED, IDX_W'($urandom), $urandom);
    end else begin
      // noise: a write that may break the ordering
      slot = $urandom_range(0, TABLE_DEPTH - 1);
      key  = $urandom;
      table_image[slot] = key;
      send_request(OP_WRITE, IDX_W'(slot), key);
    end
  endtask

  initial begin
    int unsigned      phase_counts [7];
    int unsigned      phase_lengths [7];
    logic [KEY_W-1:0] key;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty table after reset: searches answer index 0, no hit
    send_request(OP_NEAREST, '0, '0);
    send_request(OP_EXACT, '1, KEY_MAX);
    send_request(OP_UNUSED, '1, KEY_MAX);
    send_request(OP_WRITE, IDX_W'(0), 32'd10);
    send_request(OP_WRITE, IDX_W'(1), 32'd20);
    send_request(OP_WRITE, IDX_W'(TABLE_DEPTH - 1), KEY_MAX);
    send_request(OP_EXACT, '0, 32'd10);

    // two live entries {10, 20}
    set_entry_count(2);
    send_request(OP_NEAREST, '0, 32'd10);
    send_request(OP_EXACT, '0, 32'd20);
    send_request(OP_NEAREST, '0, 32'd3);     // below every entry
    send_request(OP_NEAREST, '0, 32'd15);    // between entries
    send_request(OP_EXACT, '0, 32'd25);      // above every entry
    send_request(OP_NEAREST, '1, KEY_MAX);
    send_request(OP_EXACT, '1, '0);
    send_request(OP_WRITE, IDX_W'(1), 32'd10);  // duplicate keys
    send_request(OP_EXACT, '0, 32'd10);
    send_request(OP_UNUSED, '0, '0);
    send_request(OP_WRITE, IDX_W'(512), '0);

    // fill the whole table in ascending order, duplicates now and then
    key = $urandom_range(0, 100);
    for (int unsigned i = 0; i < TABLE_DEPTH; i++) begin
      if (i == TABLE_DEPTH - 1) key = KEY_MAX;
      else if (i > 0 && $urandom_range(0, 9) != 0) key = key + $urandom_range(1, 4000000);
      table_image[i] = key;
      send_request(OP_WRITE, IDX_W'(i), key);
    end

    // count settings: full, saturated, single entry, just above depth, empty, random, half
    phase_counts  = '{1024, 2047, 1, 1025, 0, 0, 512};
    phase_lengths = '{300, 120, 60, 80, 30, 100, 100};
    phase_counts[5] = $urandom_range(3, TABLE_DEPTH - 1);
    for (int unsigned p = 0; p < 7; p++) begin
      set_entry_count(phase_counts[p]);
      for (int unsigned k = 0; k < phase_lengths[p]; k++) begin
        // in the first phase the sender pauses once midway until the block has emptied out
        if (p == 0 && k == phase_lengths[0] / 2) drain_results();
        random_request();
      end
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
